// ===== rtl/pkek_pkg.sv =====
`timescale 1ns / 1ps

package pkek_pkg;

   localparam int DEF_MAX_KEY_LEN = 64;
   localparam int DEF_MAX_BLOCK   = 8;

   localparam logic [6:0] KEY_LEN_RESET = 7'd8;

   localparam logic [2:0] REQ_FILL    = 3'd0;
   localparam logic [2:0] REQ_SWAP    = 3'd1;
   localparam logic [2:0] REQ_REVERSE = 3'd2;
   localparam logic [2:0] REQ_MOVE    = 3'd3;
   localparam logic [2:0] REQ_READ    = 3'd4;

   localparam logic [1:0] ST_APPLIED  = 2'd0;
   localparam logic [1:0] ST_NOCHANGE = 2'd1;
   localparam logic [1:0] ST_REJECT   = 2'd2;

   // ring control from the head: rotate, mark the entry entering the ring,
   // load broadcast block into marked entries
   typedef struct packed {
      logic shift;
      logic mark;
      logic load;
   } ring_ctl_type;

endpackage

// ===== rtl/pkek_cell.sv =====
`timescale 1ns / 1ps

module pkek_cell #(
   parameter int EW        = 6,
   parameter int NB        = pkek_pkg::DEF_MAX_BLOCK,
   parameter int RESET_VAL = 0,
   localparam int TW       = $clog2(NB)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pkek_pkg::ring_ctl_type ctl,
   input  logic [EW-1:0]         up_value,
   input  logic                  up_mark,
   input  logic [TW-1:0]         up_tag,
   input  logic [EW-1:0]         bus [NB],
   output logic [EW-1:0]         value,
   output logic                  mark,
   output logic [TW-1:0]         tag
);
   import pkek_pkg::*;

   logic [EW-1:0] value_ff;
   logic          mark_ff;
   logic [TW-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= EW'(RESET_VAL);
         mark_ff  <= 1'b0;
      end else if (ctl.shift) begin
         tag_ff <= up_tag;
         if (ctl.load && up_mark) begin
            value_ff <= bus[up_tag];
            mark_ff  <= 1'b0;
         end else begin
            value_ff <= up_value;
            mark_ff  <= up_mark;
         end
      end
   end

   assign value = value_ff;
   assign mark  = mark_ff;
   assign tag   = tag_ff;

endmodule

// ===== rtl/pkek_ring.sv =====
`timescale 1ns / 1ps

module pkek_ring #(
   parameter int MAX_KEY_LEN = pkek_pkg::DEF_MAX_KEY_LEN,
   parameter int MAX_BLOCK   = pkek_pkg::DEF_MAX_BLOCK,
   localparam int EW         = $clog2(MAX_KEY_LEN),
   localparam int TW         = $clog2(MAX_BLOCK)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pkek_pkg::ring_ctl_type ctl,
   input  logic [EW-1:0]          head_value,
   input  logic [TW-1:0]          head_tag,
   output logic [EW-1:0]          taps [MAX_BLOCK+1]
);
   import pkek_pkg::*;

   logic [EW-1:0] val  [MAX_KEY_LEN];
   logic          mk   [MAX_KEY_LEN];
   logic [TW-1:0] tg   [MAX_KEY_LEN];
   logic [EW-1:0] bus  [MAX_BLOCK];

   for (genvar j = 0; j < MAX_KEY_LEN; j++) begin : g_cell
      logic [EW-1:0] up_value;
      logic          up_mark;
      logic [TW-1:0] up_tag;

      if (j == MAX_KEY_LEN - 1) begin : g_tail
         assign up_value = head_value;
         assign up_mark  = ctl.mark;
         assign up_tag   = head_tag;
      end else begin : g_mid
         assign up_value = val[j+1];
         assign up_mark  = mk[j+1];
         assign up_tag   = tg[j+1];
      end

      pkek_cell #(
         .EW        (EW),
         .NB        (MAX_BLOCK),
         .RESET_VAL (j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .up_value (up_value),
         .up_mark  (up_mark),
         .up_tag   (up_tag),
         .bus      (bus),
         .value    (val[j]),
         .mark     (mk[j]),
         .tag      (tg[j])
      );
   end

   for (genvar j = 0; j <= MAX_BLOCK; j++) begin : g_tap
      if (j < MAX_KEY_LEN) begin : g_on
         assign taps[j] = val[j];
      end else begin : g_off
         assign taps[j] = '0;
      end
   end

   for (genvar j = 0; j < MAX_BLOCK; j++) begin : g_bus
      assign bus[j] = taps[j];
   end

endmodule

// ===== rtl/permutation_key_edit_engine_unit.sv =====
`timescale 1ns / 1ps
// Fill, swap, reverse, move and an accepted read take one revolution of the
// key ring in S_RUN, then S_FINISH registers the result.
// Rejected, no-change and self-swap requests answer from idle, one per cycle
// while the result is not stalled. No request is taken during a ring pass;
// a stalled result holds off the next transaction. Synchronous reset loads
// the identity key and key_length 8.
module permutation_key_edit_engine_unit #(
   parameter int MAX_KEY_LEN = pkek_pkg::DEF_MAX_KEY_LEN,
   parameter int MAX_BLOCK   = pkek_pkg::DEF_MAX_BLOCK
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  logic [5:0] req_first_pos,
   input  logic [5:0] req_second_pos,
   input  logic [3:0] req_block_len,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_read_value,
   output logic [1:0] rsp_status
);
   import pkek_pkg::*;

   localparam int N   = MAX_KEY_LEN;
   localparam int NB  = MAX_BLOCK;
   localparam int EW  = $clog2(N);
   localparam int KW  = $clog2(N + 1);
   localparam int PW  = $clog2(N);
   localparam int TW  = $clog2(NB);
   localparam int TIW = $clog2(NB + 1);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH} state_type;

   state_type     state_ff;
   logic [PW-1:0] pos_ff;
   logic [2:0]    op_ff;
   logic [5:0]    a_ff;
   logic [5:0]    b_ff;
   logic [3:0]    blk_ff;
   logic [6:0]    key_length_ff;
   logic [EW-1:0] held_ff [NB];
   logic [EW-1:0] hist_ff [NB];
   logic [EW-1:0] sv_ff;
   logic [EW-1:0] rd_ff;
   logic          rsp_valid_ff;
   logic [5:0]    rsp_read_value_ff;
   logic [1:0]    rsp_status_ff;

   logic [KW-1:0] k;
   logic          req_fire;
   logic          go_pass;
   logic          rsp_load;
   logic [1:0]    imm_status;
   logic [5:0]    a_in;
   logic [5:0]    b_in;

   ring_ctl_type  ctl;
   logic [EW-1:0] head_value;
   logic [TW-1:0] head_tag;
   logic [EW-1:0] taps    [NB+1];
   logic [EW-1:0] blk_now [NB];
   logic          cap_held;
   logic          cap_sv;
   logic          cap_rd;

   assign k = (int'(key_length_ff) > N) ? KW'(N) : KW'(key_length_ff);

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_FINISH) || (state_ff == S_IDLE && req_fire && !go_pass);

   always_comb begin
      int kk, ra, rb, rl;
      kk = int'(k);
      ra = int'(req_first_pos);
      rb = int'(req_second_pos);
      rl = int'(req_block_len);
      go_pass    = 1'b0;
      imm_status = ST_REJECT;
      a_in       = req_first_pos;
      b_in       = req_second_pos;
      unique case (req_type)
         REQ_FILL: go_pass = 1'b1;
         REQ_SWAP: begin
            if (kk < 2) imm_status = ST_NOCHANGE;
            else if (ra >= kk || rb >= kk) imm_status = ST_REJECT;
            else if (ra == rb) imm_status = ST_APPLIED;
            else begin
               go_pass = 1'b1;
               a_in    = (ra < rb) ? req_first_pos : req_second_pos;
               b_in    = (ra < rb) ? req_second_pos : req_first_pos;
            end
         end
         REQ_REVERSE: begin
            if (kk < 2) imm_status = ST_NOCHANGE;
            else if (rl < 2 || rl > NB || rl > kk || ra + rl > kk) imm_status = ST_REJECT;
            else go_pass = 1'b1;
         end
         REQ_MOVE: begin
            if (kk < 2) imm_status = ST_NOCHANGE;
            else if (rl < 1 || rl > NB || rl > kk || ra + rl > kk || rb + rl > kk)
               imm_status = ST_REJECT;
            else if (ra == rb) imm_status = ST_NOCHANGE;
            else go_pass = 1'b1;
         end
         REQ_READ: begin
            if (ra < kk) go_pass = 1'b1;
            else imm_status = ST_REJECT;
         end
         default: imm_status = ST_REJECT;
      endcase
   end

   for (genvar j = 0; j < NB; j++) begin : g_now
      assign blk_now[j] = (pos_ff == PW'(a_ff)) ? taps[j] : held_ff[j];
   end

   // head cell: decides what re-enters the ring at key position pos_ff
   always_comb begin
      int p, s, d, bl, kk;
      p  = int'(pos_ff);
      s  = int'(a_ff);
      d  = int'(b_ff);
      bl = int'(blk_ff);
      kk = int'(k);
      ctl        = '0;
      head_value = taps[0];
      head_tag   = '0;
      cap_held   = 1'b0;
      cap_sv     = 1'b0;
      cap_rd     = 1'b0;
      if (state_ff == S_RUN) begin
         ctl.shift = 1'b1;
         case (op_ff)
            REQ_FILL: begin
               if (p < kk) head_value = EW'(pos_ff);
            end
            REQ_SWAP: begin
               if (p == s) begin
                  ctl.mark = 1'b1;
                  cap_sv   = 1'b1;
               end else if (p == d) begin
                  head_value = sv_ff;
                  ctl.load   = 1'b1;
               end
            end
            REQ_REVERSE: begin
               if (p == s) cap_held = 1'b1;
               if (p >= s && p < s + bl) head_value = blk_now[TW'(s + bl - 1 - p)];
            end
            REQ_MOVE: begin
               if (p == s) begin
                  cap_held = 1'b1;
                  if (d < s) ctl.load = 1'b1;
               end
               if (d > s) begin
                  if (p >= s && p < d) head_value = taps[TIW'(blk_ff)];
                  else if (p >= d && p < d + bl) head_value = held_ff[TW'(p - d)];
               end else begin
                  if (p >= d && p < d + bl) begin
                     if (p < s) begin
                        ctl.mark = 1'b1;
                        head_tag = TW'(p - d);
                     end else begin
                        head_value = blk_now[TW'(p - d)];
                     end
                  end else if (p >= d + bl && p < s + bl) begin
                     head_value = hist_ff[TW'(bl - 1)];
                  end
               end
            end
            REQ_READ: begin
               if (p == s) cap_rd = 1'b1;
            end
            default: ;
         endcase
      end
   end

   pkek_ring #(
      .MAX_KEY_LEN (MAX_KEY_LEN),
      .MAX_BLOCK   (MAX_BLOCK)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .head_value (head_value),
      .head_tag   (head_tag),
      .taps       (taps)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         key_length_ff <= KEY_LEN_RESET;
      end else begin
         if (csr_write_enable) key_length_ff <= csr_write_data;
         if (rsp_valid_ff && !rsp_stall && !rsp_load) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff  <= req_type;
                  a_ff   <= a_in;
                  b_ff   <= b_in;
                  blk_ff <= req_block_len;
                  pos_ff <= '0;
                  if (go_pass) begin
                     state_ff <= S_RUN;
                  end else begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_read_value_ff <= '0;
                     rsp_status_ff     <= imm_status;
                  end
               end
            end
            S_RUN: begin
               hist_ff[0] <= taps[0];
               for (int j = 1; j < NB; j++) hist_ff[j] <= hist_ff[j-1];
               if (cap_held) begin
                  for (int j = 0; j < NB; j++) held_ff[j] <= taps[j];
               end
               if (cap_sv) sv_ff <= taps[0];
               if (cap_rd) rd_ff <= taps[0];
               pos_ff <= pos_ff + PW'(1);
               if (pos_ff == PW'(N - 1)) state_ff <= S_FINISH;
            end
            S_FINISH: begin
               rsp_valid_ff      <= 1'b1;
               rsp_read_value_ff <= (op_ff == REQ_READ) ? 6'(rd_ff) : 6'd0;
               rsp_status_ff     <= ST_APPLIED;
               state_ff          <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== rtl/pkek_checker.sv =====
`timescale 1ns / 1ps

module pkek_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [2:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [5:0] rsp_read_value,
   input logic [1:0] rsp_status
);
   import pkek_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_APPLIED |-> rsp_read_value == 6'd0)
      else $error("read value nonzero on unapplied transaction");

   a_bad_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type != REQ_FILL && req_type != REQ_SWAP &&
      req_type != REQ_REVERSE && req_type != REQ_MOVE && req_type != REQ_READ
      |=> rsp_valid && rsp_status == ST_REJECT)
      else $error("unknown request not rejected at once");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("response repeated or invented");

endmodule

bind permutation_key_edit_engine_unit pkek_checker u_pkek_checker (.*);
